>>> sv/skvt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_pkg
// Request and status codes and the control types shared by the sorted
// key/value table modules.
// ----------------------------------------------------------------------------
package skvt_pkg;

	// request kinds
	localparam logic [2:0] REQ_INSERT = 3'd0;
	localparam logic [2:0] REQ_LOOKUP = 3'd1;
	localparam logic [2:0] REQ_REMOVE = 3'd2;
	localparam logic [2:0] REQ_CLEAR  = 3'd3;
	localparam logic [2:0] REQ_READ   = 3'd4;

	// result status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;
	localparam logic [1:0] ST_RANGE     = 2'd3;

	// commands from controller to datapath
	typedef struct packed {
		logic load;
		logic step;
		logic exec;
	} cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic search_done;
	} stat_t;

endpackage

>>> sv/skvt_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_ctrl
// Controller: takes an item, runs the binary search one step per cycle and
// then issues the single execute command that updates the table.
// ----------------------------------------------------------------------------
module skvt_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          start,
	input  skvt_pkg::stat_t stat,
	output skvt_pkg::cmd_t  cmd,
	output logic          busy
);
	import skvt_pkg::*;

	localparam logic ST_IDLE   = 1'b0;
	localparam logic ST_SEARCH = 1'b1;

	logic state_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (start) state_q <= ST_SEARCH;
				end
				ST_SEARCH: begin
					if (stat.search_done) state_q <= ST_IDLE;
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// command decode
	always_comb begin
		cmd.load = (state_q == ST_IDLE) && start;
		cmd.step = (state_q == ST_SEARCH) && !stat.search_done;
		cmd.exec = (state_q == ST_SEARCH) && stat.search_done;
	end

	assign busy = (state_q == ST_SEARCH);

endmodule

>>> sv/skvt_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// skvt_datapath
// Table cells, request registers, binary search bounds and result
// registers. Insert and remove shift all cells at once.
// ----------------------------------------------------------------------------
module skvt_datapath #(
	parameter int DEPTH      = 16,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  skvt_pkg::cmd_t        cmd,
	output skvt_pkg::stat_t       stat,
	input  logic [2:0]            req_type,
	input  logic [KEY_WIDTH-1:0]  key,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [IDX_W-1:0]      index,
	output logic                  done,
	output logic [1:0]            status,
	output logic [KEY_WIDTH-1:0]  key_out,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [CNT_W-1:0]      position,
	output logic [CNT_W-1:0]      entry_count
);
	import skvt_pkg::*;

	localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(DEPTH);

	// request registers
	logic [2:0]            req_q;
	logic [KEY_WIDTH-1:0]  key_q;
	logic [DATA_WIDTH-1:0] data_q;
	logic [IDX_W-1:0]      idx_q;

	// search bounds and fill count
	logic [CNT_W-1:0] lo_q;
	logic [CNT_W-1:0] hi_q;
	logic [CNT_W-1:0] count_q;

	// table cells
	logic [KEY_WIDTH-1:0]  key_cells_q  [DEPTH];
	logic [DATA_WIDTH-1:0] data_cells_q [DEPTH];

	// result registers
	logic                  done_q;
	logic [1:0]            status_q;
	logic [KEY_WIDTH-1:0]  key_out_q;
	logic [DATA_WIDTH-1:0] data_out_q;
	logic [CNT_W-1:0]      position_q;

	logic [CNT_W:0]        mid_sum;
	logic [CNT_W-1:0]      mid;
	logic                  mid_less;
	logic                  search_kind;
	logic                  hit;
	logic                  ins_ok;
	logic                  rem_ok;
	logic                  rd_ok;
	logic [CNT_W-1:0]      idx_ext;
	logic [CNT_W-1:0]      count_nxt;
	logic [1:0]            status_nxt;
	logic [KEY_WIDTH-1:0]  key_out_nxt;
	logic [DATA_WIDTH-1:0] data_out_nxt;
	logic [CNT_W-1:0]      position_nxt;

	// one halving step of the lower-bound search
	assign mid_sum  = {1'b0, lo_q} + {1'b0, hi_q};
	assign mid      = mid_sum[CNT_W:1];
	assign mid_less = key_cells_q[mid[IDX_W-1:0]] < key_q;
	assign stat.search_done = (lo_q == hi_q);

	assign search_kind = (req_type inside {REQ_INSERT, REQ_LOOKUP, REQ_REMOVE});

	// request capture and search bounds
	always_ff @(posedge clk) begin
		if (cmd.load) begin
			req_q  <= req_type;
			key_q  <= key;
			data_q <= data_in;
			idx_q  <= index;
			lo_q   <= '0;
			hi_q   <= search_kind ? count_q : '0;
		end else if (cmd.step) begin
			if (mid_less) lo_q <= mid + CNT_W'(1);
			else hi_q <= mid;
		end
	end

	// outcome of the request at the found position
	always_comb begin
		idx_ext      = CNT_W'(idx_q);
		hit          = (lo_q < count_q) && (key_cells_q[lo_q[IDX_W-1:0]] == key_q);
		ins_ok       = (req_q == REQ_INSERT) && (count_q < FULL_COUNT);
		rem_ok       = (req_q == REQ_REMOVE) && hit;
		rd_ok        = (req_q == REQ_READ) && (idx_ext < count_q);
		count_nxt    = count_q;
		status_nxt   = ST_OK;
		key_out_nxt  = '0;
		data_out_nxt = '0;
		position_nxt = '0;
		case (req_q)
			REQ_INSERT: begin
				position_nxt = lo_q;
				if (ins_ok) count_nxt = count_q + CNT_W'(1);
				else status_nxt = ST_FULL;
			end
			REQ_LOOKUP: begin
				position_nxt = lo_q;
				if (hit) data_out_nxt = data_cells_q[lo_q[IDX_W-1:0]];
				else status_nxt = ST_NOT_FOUND;
			end
			REQ_REMOVE: begin
				position_nxt = lo_q;
				if (rem_ok) count_nxt = count_q - CNT_W'(1);
				else status_nxt = ST_NOT_FOUND;
			end
			REQ_CLEAR: begin
				count_nxt = '0;
			end
			REQ_READ: begin
				position_nxt = idx_ext;
				if (rd_ok) begin
					key_out_nxt  = key_cells_q[idx_q];
					data_out_nxt = data_cells_q[idx_q];
				end else begin
					status_nxt = ST_RANGE;
				end
			end
			default: begin
			end
		endcase
	end

	// fill count and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			done_q <= cmd.exec;
			if (cmd.exec) count_q <= count_nxt;
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (cmd.exec) begin
			status_q   <= status_nxt;
			key_out_q  <= key_out_nxt;
			data_out_q <= data_out_nxt;
			position_q <= position_nxt;
		end
	end

	// cells: shift up on insert, shift down on remove
	for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
		localparam logic [CNT_W-1:0] POS = CNT_W'(gi);
		always_ff @(posedge clk) begin
			if (cmd.exec && ins_ok) begin
				if (POS == lo_q) begin
					key_cells_q[gi]  <= key_q;
					data_cells_q[gi] <= data_q;
				end else if (gi > 0 && POS > lo_q && POS <= count_q) begin
					key_cells_q[gi]  <= key_cells_q[(gi > 0) ? gi - 1 : 0];
					data_cells_q[gi] <= data_cells_q[(gi > 0) ? gi - 1 : 0];
				end
			end else if (cmd.exec && rem_ok) begin
				if (gi < DEPTH - 1 && POS >= lo_q && POS + CNT_W'(1) < count_q) begin
					key_cells_q[gi]  <= key_cells_q[(gi < DEPTH - 1) ? gi + 1 : gi];
					data_cells_q[gi] <= data_cells_q[(gi < DEPTH - 1) ? gi + 1 : gi];
				end
			end
		end
	end

	assign done        = done_q;
	assign status      = status_q;
	assign key_out     = key_out_q;
	assign data_out    = data_out_q;
	assign position    = position_q;
	assign entry_count = count_q;

endmodule

>>> sv/sorted_key_value_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_key_value_table
// Table of key/data pairs kept in ascending key order, with binary search,
// insert, lookup, remove, clear and read by position.
// ----------------------------------------------------------------------------
// An item is taken at a clock edge where start is high and busy is low. The
// lower-bound search runs one halving step per cycle over the current
// entries (at most $clog2(entries+1) steps, none for clear and read), then
// the execute command applies the request, shifting all cells at once. The
// result shows on the outputs for exactly one cycle with done high, which is
// registered from the execute command; it must be captured then, as the
// block does not wait. busy is already low in that cycle, so the next item
// can be taken while the result is shown. entry_count always shows the
// current fill count.
module sorted_key_value_table #(
	parameter int DEPTH      = 16,
	parameter int KEY_WIDTH  = 32,
	parameter int DATA_WIDTH = 32,
	localparam int IDX_W     = $clog2(DEPTH),
	localparam int CNT_W     = $clog2(DEPTH + 1)
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  start,
	output logic                  busy,
	input  logic [2:0]            req_type,
	input  logic [KEY_WIDTH-1:0]  key,
	input  logic [DATA_WIDTH-1:0] data_in,
	input  logic [IDX_W-1:0]      index,
	output logic                  done,
	output logic [1:0]            status,
	output logic [KEY_WIDTH-1:0]  key_out,
	output logic [DATA_WIDTH-1:0] data_out,
	output logic [CNT_W-1:0]      position,
	output logic [CNT_W-1:0]      entry_count
);
	import skvt_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// controller
	skvt_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy)
	);

	// datapath
	skvt_datapath #(
		.DEPTH      (DEPTH),
		.KEY_WIDTH  (KEY_WIDTH),
		.DATA_WIDTH (DATA_WIDTH)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.stat        (stat),
		.req_type    (req_type),
		.key         (key),
		.data_in     (data_in),
		.index       (index),
		.done        (done),
		.status      (status),
		.key_out     (key_out),
		.data_out    (data_out),
		.position    (position),
		.entry_count (entry_count)
	);

`ifndef NO_ASSERTIONS
	// a result is only shown once the controller has gone idle
	a_done_idle: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> !busy)
		else $error("result shown while busy");

	// an accepted item always keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted item did not start a search");

	// fill count never exceeds the table depth
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		entry_count <= CNT_W'(DEPTH))
		else $error("entry count beyond depth");

	// a full status only when the table really is full
	a_full_count: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == ST_FULL) |-> (entry_count == CNT_W'(DEPTH)))
		else $error("full status with free entries");
`endif

endmodule
